// ===== rtl/sbfd_pkg.sv =====
// ---------------------------------------------------------------------------
// sbfd_pkg
// Shared constants and types for the sbus frame decoder.
// ---------------------------------------------------------------------------
package sbfd_pkg;

  localparam int CHANNEL_COUNT = 16;
  localparam int CHANNEL_BITS  = 11;
  localparam int INDEX_BITS    = 4;
  localparam int FRAME_LEN     = 25;
  localparam int PAYLOAD_LEN   = 22;
  localparam int PAYLOAD_BITS  = PAYLOAD_LEN * 8;
  localparam int POS_BITS      = 5;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] HEADER_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE    = 8'h00;

  localparam logic [POS_BITS-1:0] POS_HEADER = POS_BITS'(0);
  localparam logic [POS_BITS-1:0] POS_LAST_PAYLOAD = POS_BITS'(PAYLOAD_LEN);
  localparam logic [POS_BITS-1:0] POS_END = POS_BITS'(FRAME_LEN - 1);
  localparam logic [POS_BITS-1:0] POS_DONE = POS_BITS'(FRAME_LEN);

  typedef logic [PAYLOAD_BITS-1:0] payload_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== rtl/sbfd_front.sv =====
// ---------------------------------------------------------------------------
// sbfd_front
// Tracks the byte position in a frame, checks header and end byte and
// collects the payload; pushes a payload snapshot for each good frame.
// ---------------------------------------------------------------------------
module sbfd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  logic [7:0]            rx_byte,
  input  logic                  frame_start,
  input  sbfd_pkg::queue_status_t q_status,
  output logic                  push,
  output sbfd_pkg::payload_t    push_data
);

  logic [sbfd_pkg::POS_BITS-1:0] byte_position;
  logic [sbfd_pkg::POS_BITS-1:0] pos_cur;
  logic                          header_seen;
  logic [7:0]                    payload_store [sbfd_pkg::PAYLOAD_LEN];
  logic                          accept;

  // an end byte can only go forward when the queue has room
  assign byte_stall = q_status.full && (byte_position == sbfd_pkg::POS_END);
  assign accept     = byte_valid && !byte_stall;
  assign pos_cur    = frame_start ? sbfd_pkg::POS_HEADER : byte_position;

  assign push = accept && (pos_cur == sbfd_pkg::POS_END) && header_seen &&
                (rx_byte == sbfd_pkg::END_BYTE);

  always_comb begin
    for (int i = 0; i < sbfd_pkg::PAYLOAD_LEN; i++) begin
      push_data[i*8 +: 8] = payload_store[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= sbfd_pkg::POS_HEADER;
      header_seen   <= 1'b0;
    end else if (accept && (pos_cur != sbfd_pkg::POS_DONE)) begin
      if (pos_cur == sbfd_pkg::POS_HEADER) begin
        header_seen <= (rx_byte == sbfd_pkg::HEADER_BYTE);
      end
      byte_position <= pos_cur + 1'b1;
    end else if (accept) begin
      // past the frame: position parks at the done value
      byte_position <= sbfd_pkg::POS_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (pos_cur != sbfd_pkg::POS_HEADER) &&
        (pos_cur <= sbfd_pkg::POS_LAST_PAYLOAD)) begin
      payload_store[pos_cur - 1'b1] <= rx_byte;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    byte_position <= sbfd_pkg::POS_DONE)
    else $error("byte position beyond frame");

  assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("push into full queue");

  assert property (@(posedge clk) disable iff (rst)
    (accept && frame_start) |=> (byte_position == sbfd_pkg::POS_HEADER + 1'b1))
    else $error("frame start did not restart position");

endmodule

// ===== rtl/sbfd_queue.sv =====
// ---------------------------------------------------------------------------
// sbfd_queue
// Two-entry queue of frame payloads between front and back.
// ---------------------------------------------------------------------------
module sbfd_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  sbfd_pkg::payload_t      push_data,
  input  logic                    pop,
  output sbfd_pkg::payload_t      pop_data,
  output sbfd_pkg::queue_status_t status
);

  localparam int PtrBits = $clog2(sbfd_pkg::QUEUE_DEPTH);

  sbfd_pkg::payload_t   entries [sbfd_pkg::QUEUE_DEPTH];
  logic [PtrBits-1:0]   wr_ptr;
  logic [PtrBits-1:0]   rd_ptr;
  logic [PtrBits:0]     count;

  assign status.full  = (count == (PtrBits+1)'(sbfd_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrBits'(sbfd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrBits'(sbfd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("pop from empty queue");

  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a push");

  assert property (@(posedge clk) disable iff (rst)
    count <= (PtrBits+1)'(sbfd_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");

endmodule

// ===== rtl/sbfd_back.sv =====
// ---------------------------------------------------------------------------
// sbfd_back
// Unpacks one queued payload into channel results, 11 bits per transfer,
// through a shift register and an output register.
// ---------------------------------------------------------------------------
module sbfd_back (
  input  logic                                clk,
  input  logic                                rst,
  input  sbfd_pkg::queue_status_t             q_status,
  output logic                                pop,
  input  sbfd_pkg::payload_t                  pop_data,
  output logic                                channel_valid,
  input  logic                                channel_stall,
  output logic [sbfd_pkg::INDEX_BITS-1:0]     channel_index,
  output logic [sbfd_pkg::CHANNEL_BITS-1:0]   channel_value,
  output logic                                last_channel
);

  localparam logic [sbfd_pkg::INDEX_BITS-1:0] LastIndex =
    sbfd_pkg::INDEX_BITS'(sbfd_pkg::CHANNEL_COUNT - 1);

  logic                              busy;
  sbfd_pkg::payload_t                shreg;
  logic [sbfd_pkg::INDEX_BITS-1:0]   ch;
  logic                              advance;

  assign advance = busy && (!channel_valid || !channel_stall);
  assign pop     = !busy && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      ch            <= '0;
      channel_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        ch   <= '0;
      end else if (advance) begin
        ch <= ch + 1'b1;
        if (ch == LastIndex) begin
          busy <= 1'b0;
        end
      end
      if (advance) begin
        channel_valid <= 1'b1;
      end else if (channel_valid && !channel_stall) begin
        channel_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shreg <= pop_data;
    end else if (advance) begin
      shreg <= shreg >> sbfd_pkg::CHANNEL_BITS;
    end
    if (advance) begin
      channel_index <= ch;
      channel_value <= shreg[sbfd_pkg::CHANNEL_BITS-1:0];
      last_channel  <= (ch == LastIndex);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> (ch == '0))
    else $error("frame unpack did not start at channel 0");

  assert property (@(posedge clk) disable iff (rst)
    (channel_valid && last_channel) |-> (channel_index == LastIndex))
    else $error("last channel flag on wrong index");

  assert property (@(posedge clk) disable iff (rst)
    (advance && (ch == LastIndex)) |=> !busy)
    else $error("unpack ran past last channel");

endmodule

// ===== rtl/sbus_frame_decoder_unit.sv =====
// ---------------------------------------------------------------------------
// sbus_frame_decoder_unit
// Decodes 25-byte sbus frames into 16 channel results of 11 bits each.
// ---------------------------------------------------------------------------
// after the end byte, a frame passes the queue, shift register and output register
// throughput: one byte per cycle unless stalled; a good frame yields one channel per
//   cycle when not stalled, 16 in a row, from the back unpacker fed by a two-frame queue
// bytes stall only at the end byte position while the queue is full
// synchronous reset clears position, header flag, queue and output valid
module sbus_frame_decoder_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                byte_valid,
  output logic                                byte_stall,
  input  logic [7:0]                          rx_byte,
  input  logic                                frame_start,
  output logic                                channel_valid,
  input  logic                                channel_stall,
  output logic [sbfd_pkg::INDEX_BITS-1:0]     channel_index,
  output logic [sbfd_pkg::CHANNEL_BITS-1:0]   channel_value,
  output logic                                last_channel
);

  sbfd_pkg::queue_status_t q_status;
  sbfd_pkg::payload_t      push_data;
  sbfd_pkg::payload_t      pop_data;
  logic                    push;
  logic                    pop;

  sbfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .q_status    (q_status),
    .push        (push),
    .push_data   (push_data)
  );

  sbfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  sbfd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .pop           (pop),
    .pop_data      (pop_data),
    .channel_valid (channel_valid),
    .channel_stall (channel_stall),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last_channel  (last_channel)
  );

endmodule

// ===== sim/sbus_frame_decoder_unit_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sbus_frame_decoder_unit_tb
// Feeds sbus byte streams through the frame decoder: a short table of
// directed frames (reset, extremes, bad header and end, aborted frames,
// trailing bytes) and then random frames mixed with noise. Every channel
// transfer is checked against an in-bench frame predictor, with random
// idle gaps on the byte side and random stalls on the channel side.
// ---------------------------------------------------------------------------
module sbus_frame_decoder_unit_tb;

  localparam int IB = sbfd_pkg::INDEX_BITS;
  localparam int CB = sbfd_pkg::CHANNEL_BITS;
  localparam logic [7:0] HDR_BYTE = sbfd_pkg::HEADER_BYTE;
  localparam logic [7:0] END_MARK = sbfd_pkg::END_BYTE;

  typedef enum {EXP_MODEL, EXP_NONE, EXP_CONST} exp_kind_t;
  typedef enum {FILL_ZERO, FILL_ONES, FILL_RAND, FILL_WALK} fill_t;

  typedef struct {
    logic [IB-1:0] idx;
    logic [CB-1:0] val;
    logic          is_last;
  } chan_rec_t;

  typedef struct {
    logic          start;
    logic [7:0]    hdr;
    fill_t         fill;
    logic [7:0]    flags;
    logic [7:0]    endb;
    int            cut;
    int            trail;
    exp_kind_t     kind;
    logic [CB-1:0] val;
  } frame_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          byte_valid = 1'b0;
  logic          byte_stall;
  logic [7:0]    rx_byte = 8'h00;
  logic          frame_start = 1'b0;
  logic          channel_valid;
  logic          channel_stall = 1'b0;
  logic [IB-1:0] channel_index;
  logic [CB-1:0] channel_value;
  logic          last_channel;

  // predictor state
  logic [sbfd_pkg::POS_BITS-1:0] frame_pos = '0;
  logic                          hdr_ok = 1'b0;
  logic [7:0]                    payload_bytes [sbfd_pkg::PAYLOAD_LEN];

  chan_rec_t  frame_out [$];
  chan_rec_t  chan_expect [$];
  frame_row_t dir_rows [8];

  int  fail_count = 0;
  int  chan_checked = 0;
  int  frames_good = 0;
  int  bytes_used = 0;
  int  stall_left = 0;
  bit  quiet = 1'b0;

  sbus_frame_decoder_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .rx_byte       (rx_byte),
    .frame_start   (frame_start),
    .channel_valid (channel_valid),
    .channel_stall (channel_stall),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last_channel  (last_channel)
  );

  always #5 clk = ~clk;

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 99) < 55) return 0;
    return pick_len();
  endfunction

  // one byte into the frame predictor; channels of a finished frame land in frame_out
  function automatic void frame_predict(input logic [7:0] b, input logic s, output bit used);
    logic [sbfd_pkg::PAYLOAD_BITS-1:0] pl;
    chan_rec_t                         c;
    int                                i;
    int                                k;
    if (s) frame_pos = '0;
    used = (frame_pos < sbfd_pkg::FRAME_LEN);
    if (!used) return;
    if (frame_pos == sbfd_pkg::POS_HEADER) begin
      hdr_ok = (b == HDR_BYTE);
    end else if (frame_pos <= sbfd_pkg::POS_LAST_PAYLOAD) begin
      payload_bytes[frame_pos - 1'b1] = b;
    end else if (frame_pos == sbfd_pkg::POS_END && hdr_ok && b == END_MARK) begin
      for (i = 0; i < sbfd_pkg::PAYLOAD_LEN; i++) pl[i*8 +: 8] = payload_bytes[i];
      for (k = 0; k < sbfd_pkg::CHANNEL_COUNT; k++) begin
        c.idx = IB'(k);
        c.val = pl[k*CB +: CB];
        c.is_last = (k == sbfd_pkg::CHANNEL_COUNT - 1);
        frame_out.push_back(c);
      end
    end
    frame_pos = frame_pos + 1'b1;
  endfunction

  // called at a rising edge, returns at the rising edge of the transfer
  task automatic send_byte(input logic [7:0] b, input logic s, input exp_kind_t kind,
                           input logic [CB-1:0] val);
    int        gap;
    bit        used;
    int        k;
    chan_rec_t c;
    gap = pick_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid  <= 1'b1;
    rx_byte     <= b;
    frame_start <= s;
    forever begin
      @(negedge clk);
      if (!byte_stall) break;
    end
    frame_out.delete();
    frame_predict(b, s, used);
    if (used) bytes_used++;
    if (frame_out.size() > 0) begin
      frames_good++;
      case (kind)
        EXP_MODEL: begin
          foreach (frame_out[i]) chan_expect.push_back(frame_out[i]);
        end
        EXP_CONST: begin
          for (k = 0; k < sbfd_pkg::CHANNEL_COUNT; k++) begin
            c.idx = IB'(k);
            c.val = val;
            c.is_last = (k == sbfd_pkg::CHANNEL_COUNT - 1);
            chan_expect.push_back(c);
          end
        end
        default: ;
      endcase
    end
    @(posedge clk);
  endtask

  task automatic send_frame(input frame_row_t r);
    logic [7:0] fb [sbfd_pkg::FRAME_LEN];
    int         n;
    int         i;
    fb[0] = r.hdr;
    for (i = 1; i <= sbfd_pkg::PAYLOAD_LEN; i++) begin
      case (r.fill)
        FILL_ZERO: fb[i] = 8'h00;
        FILL_ONES: fb[i] = 8'hFF;
        FILL_WALK: fb[i] = 8'h01 << (i % 8);
        default:   fb[i] = 8'($urandom);
      endcase
    end
    fb[sbfd_pkg::FRAME_LEN-2] = r.flags;
    fb[sbfd_pkg::FRAME_LEN-1] = r.endb;
    n = (r.cut > 0) ? r.cut : sbfd_pkg::FRAME_LEN;
    for (i = 0; i < n; i++) send_byte(fb[i], (i == 0) ? r.start : 1'b0, r.kind, r.val);
    for (i = 0; i < r.trail; i++) send_byte(8'($urandom), 1'b0, EXP_MODEL, '0);
  endtask

  task automatic hold_until_drained();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (chan_expect.size() != 0) @(posedge clk);
  endtask

  // channel side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      channel_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left = pick_len() - 1;
      channel_stall <= 1'b1;
    end else begin
      channel_stall <= 1'b0;
    end
  end

  // sampled mid-cycle, the transfer happens at the next rising edge
  always @(negedge clk) begin
    chan_rec_t want;
    if (!rst && channel_valid && !channel_stall) begin
      if (chan_expect.size() == 0) begin
        $error("unexpected channel transfer: index %0d value %0d last %0d",
               channel_index, channel_value, last_channel);
        fail_count++;
      end else begin
        want = chan_expect.pop_front();
        chan_checked++;
        if (channel_index !== want.idx) begin
          $error("channel_index mismatch: expected %0d, got %0d", want.idx, channel_index);
          fail_count++;
        end
        if (channel_value !== want.val) begin
          $error("channel_value mismatch: expected %0d, got %0d", want.val, channel_value);
          fail_count++;
        end
        if (last_channel !== want.is_last) begin
          $error("last_channel mismatch: expected %0d, got %0d", want.is_last, last_channel);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d channel transfers outstanding", chan_expect.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    frame_row_t r;
    int         pick;
    int         used_mark;
    int         n;

    //             start  hdr       fill       flags  end       cut trail kind       value
    dir_rows[0] = '{1'b0, HDR_BYTE, FILL_ZERO, 8'h00, END_MARK, 0,  0, EXP_CONST, 11'h000};
    dir_rows[1] = '{1'b1, HDR_BYTE, FILL_ONES, 8'hFF, END_MARK, 0,  4, EXP_CONST, 11'h7FF};
    dir_rows[2] = '{1'b1, HDR_BYTE, FILL_RAND, 8'h00, END_MARK, 9,  0, EXP_NONE,  11'h000};
    dir_rows[3] = '{1'b1, 8'h0E,    FILL_ONES, 8'h00, END_MARK, 0,  0, EXP_NONE,  11'h000};
    dir_rows[4] = '{1'b1, HDR_BYTE, FILL_RAND, 8'hA5, 8'h01,    0,  0, EXP_NONE,  11'h000};
    dir_rows[5] = '{1'b1, HDR_BYTE, FILL_WALK, 8'h5A, END_MARK, 0,  0, EXP_MODEL, 11'h000};
    dir_rows[6] = '{1'b1, HDR_BYTE, FILL_RAND, 8'h00, END_MARK, 0,  2, EXP_MODEL, 11'h000};
    dir_rows[7] = '{1'b1, 8'hFF,    FILL_ZERO, 8'h00, 8'h80,    0,  0, EXP_NONE,  11'h000};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first frame has no frame start: position is zero out of reset
    foreach (dir_rows[i]) send_frame(dir_rows[i]);
    hold_until_drained();

    used_mark = bytes_used;
    while (bytes_used - used_mark < 90) begin
      quiet = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 19);
      r.start = ($urandom_range(0, 9) != 0);
      r.hdr   = HDR_BYTE;
      r.fill  = FILL_RAND;
      r.flags = 8'($urandom);
      r.endb  = END_MARK;
      r.cut   = 0;
      r.trail = 0;
      r.kind  = EXP_MODEL;
      r.val   = '0;
      case (pick)
        12, 13: r.hdr = 8'($urandom);
        14:     r.endb = 8'($urandom_range(1, 255));
        15:     r.cut = $urandom_range(1, sbfd_pkg::FRAME_LEN - 1);
        16:     r.trail = $urandom_range(1, 6);
        18:     hold_until_drained();
        default: ;
      endcase
      if (pick == 17) begin
        n = $urandom_range(1, 12);
        repeat (n) send_byte(8'($urandom), ($urandom_range(0, 7) == 0), EXP_MODEL, '0);
      end else begin
        send_frame(r);
      end
    end
    quiet = 1'b0;

    hold_until_drained();
    repeat (40) @(posedge clk);

    $display("run covered %0d accepted frame bytes and %0d decoded frames",
             bytes_used, frames_good);
    $display("%0d channel transfers compared, %0d mismatches", chan_checked, fail_count);
    if (fail_count == 0 && chan_expect.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
